[rtl/core/assert_macros.svh]
// Assertion macros shared by the UART RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every clock edge outside reset
`define U8N1_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset
`define U8N1_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/u8n1_pkg.sv]
// Shared types, constants and FIFO pointer helpers for the 8N1 UART
package u8n1_pkg;

  localparam int FIFO_DEPTH = 16;
  localparam int PTR_W      = $clog2(FIFO_DEPTH) + 1;
  localparam int SLOT_W     = $clog2(FIFO_DEPTH);

  localparam int DATA_W     = 8;
  localparam int PERIOD_W   = 20;
  localparam int TIMER_W    = 21;
  localparam int FRAME_W    = 10;
  localparam int BITS_W     = 4;
  localparam int TX_COUNT_W = 5;
  localparam int RX_COUNT_W = 4;
  localparam int BIT_IDX_W  = $clog2(DATA_W);

  localparam logic [BITS_W-1:0]   FRAME_BITS   = BITS_W'(FRAME_W);
  localparam logic [BITS_W-1:0]   DATA_BITS    = BITS_W'(DATA_W);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(694);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index, taken from the word address
  localparam logic [APB_ADDR_W-3:0] REG_BIT_PERIOD = '0;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic              rx_line;
    logic              tx_write;
    logic [DATA_W-1:0] tx_data;
    logic              rx_read;
  } in_item_t;

  typedef struct packed {
    logic                  tx_line;
    logic [DATA_W-1:0]     rx_data;
    logic [RX_COUNT_W-1:0] rx_count;
    logic [TX_COUNT_W-1:0] tx_count;
    logic                  tx_busy;
    logic                  tx_rejected;
    logic                  rx_overrun;
  } out_item_t;

  typedef struct packed {
    logic                  line;
    logic [TX_COUNT_W-1:0] count;
    logic                  busy;
    logic                  rejected;
  } tx_status_t;

  typedef struct packed {
    logic [DATA_W-1:0]     data;
    logic [RX_COUNT_W-1:0] count;
    logic                  overrun;
  } rx_status_t;

  // pointers run modulo twice the depth so that full and empty differ
  function automatic ptr_t ptr_next(ptr_t p);
    return (p == ptr_t'(2 * FIFO_DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic slot_t ptr_slot(ptr_t p);
    ptr_t s;
    s = (p >= ptr_t'(FIFO_DEPTH)) ? p - ptr_t'(FIFO_DEPTH) : p;
    return s[SLOT_W-1:0];
  endfunction

  function automatic ptr_t fifo_fill(ptr_t head, ptr_t tail);
    return (head >= tail) ? head - tail : head + ptr_t'(2 * FIFO_DEPTH) - tail;
  endfunction

endpackage

[rtl/core/uart_8n1_full_duplex_fifo.sv]
// Top level: bit-period register, transmit and receive halves, result register
// Each item is one bit-timing tick; its result is registered and appears in the cycle after acceptance.
// Throughput: one item per cycle, set by the single result register stage;
// a new item is taken while the previous result waits, when out_ready is high.
// Reset (rst_n low, synchronous): both FIFOs empty, both lines idle, bit period 694.
// FIFO contents are not cleared; no entry is read before it is written.
`include "assert_macros.svh"

module uart_8n1_full_duplex_fifo import u8n1_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [PERIOD_W-1:0]   bit_period_r;
  logic [PERIOD_W-1:0]   period_eff;
  logic [APB_ADDR_W-3:0] reg_idx;
  logic                  step_en;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  out_item_t             result;
  tx_status_t            tx_status;
  rx_status_t            rx_status;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_BIT_PERIOD) ? APB_DATA_W'(bit_period_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_BIT_PERIOD) begin
      bit_period_r <= pwdata[PERIOD_W-1:0];
    end
  end

  // a zero period behaves as one tick
  assign period_eff = (bit_period_r == '0) ? PERIOD_W'(1) : bit_period_r;

  assign in_ready = !out_valid_r || out_ready;
  assign step_en  = in_valid && in_ready;

  u8n1_tx u_tx (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .period  (period_eff),
    .item    (in_data),
    .status  (tx_status)
  );

  u8n1_rx u_rx (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .period  (period_eff),
    .item    (in_data),
    .status  (rx_status)
  );

  assign result.tx_line     = tx_status.line;
  assign result.rx_data     = rx_status.data;
  assign result.rx_count    = rx_status.count;
  assign result.tx_count    = tx_status.count;
  assign result.tx_busy     = tx_status.busy;
  assign result.tx_rejected = tx_status.rejected;
  assign result.rx_overrun  = rx_status.overrun;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `U8N1_ASSERT(a_period_nonzero, period_eff != '0, "effective bit period is zero")
  `U8N1_IMPLIES(a_idle_line_high, out_valid_r && !out_data_r.tx_busy, out_data_r.tx_line, "tx line low while idle")
  `U8N1_IMPLIES(a_rx_empty_zero, out_valid_r && out_data_r.rx_count == '0, out_data_r.rx_data == '0, "rx data nonzero with empty FIFO")
  `U8N1_IMPLIES(a_tx_count_range, out_valid_r, out_data_r.tx_count <= TX_COUNT_W'(FIFO_DEPTH), "tx count beyond FIFO depth")

endmodule

[rtl/core/u8n1_tx.sv]
// Transmit FIFO and 8N1 frame serialiser, advanced one tick per item
module u8n1_tx import u8n1_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [PERIOD_W-1:0] period,
  input  in_item_t            item,
  output tx_status_t          status
);

  typedef enum logic {TX_IDLE, TX_FRAME} tx_phase_t;

  logic [DATA_W-1:0]  store_r [FIFO_DEPTH];
  ptr_t               head_r, head_nxt;
  ptr_t               tail_r, tail_nxt;
  logic [FRAME_W-1:0] shift_r, shift_nxt;
  logic [BITS_W-1:0]  bits_r, bits_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt, timer_dec;
  tx_phase_t          phase_r, phase_nxt;
  logic               push;
  logic               rejected;
  logic [DATA_W-1:0]  load_byte;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    timer_nxt = timer_r;
    phase_nxt = phase_r;
    push      = 1'b0;
    rejected  = 1'b0;
    timer_dec = (timer_r != '0) ? timer_r - TIMER_W'(1) : '0;

    if (item.tx_write) begin
      if (fifo_fill(head_r, tail_r) >= ptr_t'(FIFO_DEPTH)) begin
        rejected = 1'b1;
      end else begin
        push     = 1'b1;
        head_nxt = ptr_next(head_r);
      end
    end

    // a byte pushed into an empty FIFO is taken straight from the item
    load_byte = (push && ptr_slot(head_r) == ptr_slot(tail_r)) ?
                item.tx_data : store_r[ptr_slot(tail_r)];

    if (phase_r == TX_FRAME) begin
      timer_nxt = timer_dec;
      if (timer_dec == '0) begin
        if (bits_r < FRAME_BITS) begin
          shift_nxt = shift_r >> 1;
          bits_nxt  = bits_r + BITS_W'(1);
          timer_nxt = TIMER_W'(period);
        end else begin
          phase_nxt = TX_IDLE;
        end
      end
    end

    // load the next byte, start bit driven in the same tick
    if (phase_nxt == TX_IDLE && fifo_fill(head_nxt, tail_r) != '0) begin
      shift_nxt = {1'b1, load_byte, 1'b0};
      tail_nxt  = ptr_next(tail_r);
      bits_nxt  = BITS_W'(1);
      timer_nxt = TIMER_W'(period);
      phase_nxt = TX_FRAME;
    end
  end

  assign status.line     = (phase_nxt == TX_IDLE) ? 1'b1 : shift_nxt[0];
  assign status.count    = TX_COUNT_W'(fifo_fill(head_nxt, tail_nxt));
  assign status.busy     = (phase_nxt != TX_IDLE);
  assign status.rejected = rejected;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      shift_r <= '0;
      bits_r  <= '0;
      timer_r <= '0;
      phase_r <= TX_IDLE;
    end else if (step_en) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      timer_r <= timer_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && push) begin
      store_r[ptr_slot(head_r)] <= item.tx_data;
    end
  end

endmodule

[rtl/core/u8n1_rx.sv]
// Receive sampler and receive FIFO, advanced one tick per item
module u8n1_rx import u8n1_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [PERIOD_W-1:0] period,
  input  in_item_t            item,
  output rx_status_t          status
);

  typedef enum logic [1:0] {RX_IDLE, RX_DATA, RX_STOP} rx_phase_t;

  logic [DATA_W-1:0]  store_r [FIFO_DEPTH];
  ptr_t               head_r, head_nxt;
  ptr_t               tail_r, tail_nxt;
  logic [DATA_W-1:0]  shift_r, shift_nxt;
  logic [BITS_W-1:0]  bits_r, bits_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt, timer_dec;
  rx_phase_t          phase_r, phase_nxt;
  logic               push;
  logic               overrun;
  ptr_t               fill_nxt;
  slot_t              rd_slot;
  logic [DATA_W-1:0]  front;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    shift_nxt = shift_r;
    bits_nxt  = bits_r;
    timer_nxt = timer_r;
    phase_nxt = phase_r;
    push      = 1'b0;
    overrun   = 1'b0;
    timer_dec = (timer_r != '0) ? timer_r - TIMER_W'(1) : '0;

    // pop first, so a full FIFO frees a place for this tick's byte
    if (item.rx_read && fifo_fill(head_r, tail_r) != '0) begin
      tail_nxt = ptr_next(tail_r);
    end

    unique case (phase_r)
      RX_IDLE: begin
        if (!item.rx_line) begin
          // first sample at the centre of data bit 0
          timer_nxt = TIMER_W'(period) + TIMER_W'(period >> 1);
          bits_nxt  = '0;
          shift_nxt = '0;
          phase_nxt = RX_DATA;
        end
      end
      RX_DATA: begin
        timer_nxt = timer_dec;
        if (timer_dec == '0) begin
          shift_nxt = shift_r | (DATA_W'(item.rx_line) << bits_r[BIT_IDX_W-1:0]);
          bits_nxt  = bits_r + BITS_W'(1);
          timer_nxt = TIMER_W'(period);
          if (bits_nxt >= DATA_BITS) begin
            if (fifo_fill(head_r, tail_nxt) < ptr_t'(FIFO_DEPTH - 1)) begin
              push     = 1'b1;
              head_nxt = ptr_next(head_r);
            end else begin
              overrun = 1'b1;
            end
            phase_nxt = RX_STOP;
          end
        end
      end
      RX_STOP: begin
        timer_nxt = timer_dec;
        if (timer_dec == '0) begin
          phase_nxt = RX_IDLE;
        end
      end
      default: begin
        phase_nxt = RX_IDLE;
      end
    endcase
  end

  // forward a byte stored this tick when it is also the front entry
  assign fill_nxt = fifo_fill(head_nxt, tail_nxt);
  assign rd_slot  = ptr_slot(tail_nxt);
  assign front    = (push && ptr_slot(head_r) == rd_slot) ? shift_nxt : store_r[rd_slot];

  assign status.data    = (fill_nxt != '0) ? front : '0;
  assign status.count   = RX_COUNT_W'(fill_nxt);
  assign status.overrun = overrun;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      shift_r <= '0;
      bits_r  <= '0;
      timer_r <= '0;
      phase_r <= RX_IDLE;
    end else if (step_en) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      shift_r <= shift_nxt;
      bits_r  <= bits_nxt;
      timer_r <= timer_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && push) begin
      store_r[ptr_slot(head_r)] <= shift_nxt;
    end
  end

endmodule
